// ----- rtl/core/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the script token lexer: token kinds,
// character codes and the result bundle passed from the lexer stage to the
// result buffer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Longest token text before it is split into a new token.
  localparam int unsigned TEXT_CAP   = 511;
  // Width of the internal line counter; it saturates at all ones.
  localparam int unsigned LINE_BITS  = 16;
  localparam int unsigned TextCntW   = $clog2(TEXT_CAP + 1);
  localparam int unsigned TokLineW   = 16;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);
  localparam int unsigned ResIdxW    = $clog2(MaxResults);

  typedef enum logic [3:0] {
    KIND_EOF    = 4'd0,
    KIND_WORD   = 4'd1,
    KIND_STRING = 4'd2,
    KIND_LBRACE = 4'd3,
    KIND_RBRACE = 4'd4,
    KIND_EQUALS = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_NEWLINE = 4'd8
  } token_kind_e;

  typedef enum logic {
    EV_TEXT = 1'b0,
    EV_DONE = 1'b1
  } event_e;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    event_e                ev;
    token_kind_e           kind;
    logic [7:0]            text;
    logic [LINE_BITS-1:0]  line;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] slot;
    logic [ResCntW-1:0]    cnt;
  } bundle_t;

endpackage

// ----- rtl/core/stl_lexer.sv -----
// ----------------------------------------------------------------------------
// stl_lexer
// Input register and lexer state. Each registered source byte is decoded
// combinationally into a bundle of up to three results, which is handed to the
// result buffer together with the state update.
// ----------------------------------------------------------------------------
module stl_lexer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       source_byte_i,
  input  logic             buf_free_i,
  output logic             load_o,
  output stl_pkg::bundle_t bundle_o
);
  import stl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_COMMENT  = 3'd1,
    MODE_WORD     = 3'd2,
    MODE_STR      = 3'd3,
    MODE_STR_ESC  = 3'd4,
    MODE_STR_FULL = 3'd5
  } mode_e;

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  mode_e                mode_q, mode_d;
  logic                 qsingle_q, qsingle_d;
  logic [TextCntW-1:0]  tc_q, tc_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [LINE_BITS-1:0] start_q, start_d;

  logic                 load;
  bundle_t              bun;

  assign load       = in_valid_q & buf_free_i;
  assign load_o     = load;
  assign bundle_o   = bun;
  assign in_stall_o = in_valid_q & ~load;

  function automatic token_kind_e punct_kind(logic [7:0] b);
    token_kind_e k;
    case (b)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_EQUALS: k = KIND_EQUALS;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_EOF;
    endcase
    return k;
  endfunction

  always_comb begin
    logic [7:0]          b;
    logic [7:0]          quote;
    token_kind_e         pk;
    logic                is_term;
    logic                close_first;
    token_kind_e         close_kind;
    logic                do_add;
    token_kind_e         add_kind;
    logic [7:0]          add_byte;
    logic                close_after;
    logic                do_idle;
    logic [TextCntW-1:0] tc_inc;
    logic [ResCntW-1:0]  n;

    b       = byte_q;
    quote   = qsingle_q ? CH_SQUOTE : CH_DQUOTE;
    pk      = punct_kind(b);
    is_term = (b inside {CH_NUL, CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF}) ||
              (pk != KIND_EOF);
    tc_inc  = tc_q + TextCntW'(1);

    mode_d    = mode_q;
    qsingle_d = qsingle_q;
    tc_d      = tc_q;
    line_d    = line_q;
    start_d   = start_q;
    bun       = '0;
    n         = '0;

    close_first = 1'b0;
    close_kind  = KIND_WORD;
    do_add      = 1'b0;
    add_kind    = KIND_WORD;
    add_byte    = b;
    close_after = 1'b0;
    do_idle     = 1'b0;

    case (mode_q)
      MODE_COMMENT: begin
        if (b == CH_NUL || b == CH_LF) do_idle = 1'b1;
      end
      MODE_WORD: begin
        if (is_term) begin
          close_first = 1'b1;
          do_idle     = 1'b1;
        end else begin
          do_add = 1'b1;
        end
      end
      MODE_STR: begin
        if (b == CH_NUL) begin
          close_first = 1'b1;
          close_kind  = KIND_STRING;
          do_idle     = 1'b1;
        end else if (b == quote) begin
          close_first = 1'b1;
          close_kind  = KIND_STRING;
          mode_d      = MODE_IDLE;
        end else if (b == CH_BSLASH) begin
          mode_d = MODE_STR_ESC;
        end else begin
          do_add   = 1'b1;
          add_kind = KIND_STRING;
        end
      end
      MODE_STR_ESC: begin
        mode_d   = MODE_STR;
        do_add   = 1'b1;
        add_kind = KIND_STRING;
        // End of source right after a backslash keeps the backslash as text.
        if (b == CH_NUL) begin
          add_byte    = CH_BSLASH;
          close_after = 1'b1;
          do_idle     = 1'b1;
        end
      end
      MODE_STR_FULL: begin
        // A closing quote right after a capped string is dropped silently.
        if (b == quote) mode_d = MODE_IDLE;
        else            do_idle = 1'b1;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (close_first) begin
      bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, close_kind, 8'h00, start_q};
      n    = n + ResCntW'(1);
      tc_d = '0;
    end

    if (do_add) begin
      bun.slot[n[ResIdxW-1:0]] = '{EV_TEXT, add_kind, add_byte, start_q};
      n = n + ResCntW'(1);
      if (tc_inc >= TextCntW'(TEXT_CAP)) begin
        bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, add_kind, 8'h00, start_q};
        n      = n + ResCntW'(1);
        tc_d   = '0;
        mode_d = (add_kind == KIND_WORD) ? MODE_IDLE : MODE_STR_FULL;
      end else begin
        tc_d = tc_inc;
      end
    end

    if (close_after && mode_d == MODE_STR) begin
      bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, KIND_STRING, 8'h00, start_q};
      n    = n + ResCntW'(1);
      tc_d = '0;
    end

    if (do_idle) begin
      mode_d = MODE_IDLE;
      if (b == CH_NUL) begin
        bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, KIND_EOF, 8'h00, line_q};
        n = n + ResCntW'(1);
      end else if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF}) begin
        mode_d = MODE_IDLE;
      end else if (b == CH_LF) begin
        bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, KIND_NEWLINE, 8'h00, line_q};
        n = n + ResCntW'(1);
        if (line_q != '1) line_d = line_q + LINE_BITS'(1);
      end else if (b == CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (pk != KIND_EOF) begin
        bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, pk, 8'h00, line_q};
        n = n + ResCntW'(1);
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        mode_d    = MODE_STR;
        qsingle_d = (b == CH_SQUOTE);
        tc_d      = '0;
        start_d   = line_q;
      end else begin
        start_d = line_q;
        bun.slot[n[ResIdxW-1:0]] = '{EV_TEXT, KIND_WORD, b, line_q};
        n = n + ResCntW'(1);
        if (TEXT_CAP == 1) begin
          bun.slot[n[ResIdxW-1:0]] = '{EV_DONE, KIND_WORD, 8'h00, line_q};
          n      = n + ResCntW'(1);
          tc_d   = '0;
          mode_d = MODE_IDLE;
        end else begin
          mode_d = MODE_WORD;
          tc_d   = TextCntW'(1);
        end
      end
    end

    bun.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= MODE_IDLE;
      qsingle_q  <= 1'b0;
      tc_q       <= '0;
      line_q     <= LINE_BITS'(1);
      start_q    <= LINE_BITS'(1);
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (load) begin
        in_valid_q <= 1'b0;
      end
      if (load) begin
        mode_q    <= mode_d;
        qsingle_q <= qsingle_d;
        tc_q      <= tc_d;
        line_q    <= line_d;
        start_q   <= start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= source_byte_i;
    end
  end

endmodule

// ----- rtl/core/stl_res_buf.sv -----
// ----------------------------------------------------------------------------
// stl_res_buf
// Result register. Holds one bundle of up to three results and presents them
// one per transfer, flagging the last result of the bundle.
// ----------------------------------------------------------------------------
module stl_res_buf (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  stl_pkg::bundle_t                bundle_i,
  output logic                            buf_free_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            event_res_o,
  output logic [3:0]                      token_kind_o,
  output logic [7:0]                      text_byte_o,
  output logic [stl_pkg::TokLineW-1:0]    token_line_o,
  output logic                            last_of_run_o
);
  import stl_pkg::*;

  res_t [MaxResults-1:0] slot_q;
  logic [ResCntW-1:0]    cnt_q;
  logic [ResIdxW-1:0]    idx_q;
  res_t                  cur;
  logic                  last;
  logic                  pop;

  assign cur         = slot_q[idx_q];
  assign out_valid_o = (cnt_q != '0);
  assign last        = (ResCntW'(idx_q) == cnt_q - ResCntW'(1));
  assign pop         = out_valid_o & ~out_stall_i;
  // A new bundle may enter as the last result of the current one leaves.
  assign buf_free_o  = ~out_valid_o | (pop & last);

  assign event_res_o   = cur.ev;
  assign token_kind_o  = cur.kind;
  assign text_byte_o   = cur.text;
  assign token_line_o  = TokLineW'(cur.line);
  assign last_of_run_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= bundle_i.cnt;
      idx_q <= '0;
    end else if (pop && last) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (pop) begin
      idx_q <= idx_q + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
  end

endmodule

// ----- rtl/core/script_token_lexer_core.sv -----
// ----------------------------------------------------------------------------
// script_token_lexer_core
// Streaming lexer for a small script language: source bytes in, token text
// and token-end results out.
// ----------------------------------------------------------------------------
// The lexer takes one source byte per cycle while in_stall_o is low; a zero
// byte marks end of source. A byte goes through an input register and is
// decoded combinationally; its results are loaded into the result register
// once that register is free and are presented from there. Most bytes give
// zero or one result; a byte that gives k results holds the result register
// for k output transfers, so the input side stalls behind it until its last
// result leaves, and also while the output side is stalled. Text of a word
// or string streams out byte by byte, followed by a token-end result with
// the kind and the start line; last_of_run_o marks the final result caused
// by one source byte.
module script_token_lexer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   source_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         event_res_o,
  output logic [3:0]                   token_kind_o,
  output logic [7:0]                   text_byte_o,
  output logic [stl_pkg::TokLineW-1:0] token_line_o,
  output logic                         last_of_run_o
);
  import stl_pkg::*;

  logic    buf_free;
  logic    load;
  bundle_t bundle;

  stl_lexer u_lexer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .source_byte_i (source_byte_i),
    .buf_free_i    (buf_free),
    .load_o        (load),
    .bundle_o      (bundle)
  );

  stl_res_buf u_res_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .bundle_i      (bundle),
    .buf_free_o    (buf_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_res_o   (event_res_o),
    .token_kind_o  (token_kind_o),
    .text_byte_o   (text_byte_o),
    .token_line_o  (token_line_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
